FILE: rtl/core/nre_pkg.sv
// Shared types and constants for the nuclear repulsion energy core.
// No dependencies; imported by nre_root_div, nuclear_repulsion_energy_core and the testbench.
package nre_pkg;

    localparam int unsigned COORD_W  = 32;
    localparam int unsigned CHARGE_W = 7;
    localparam int unsigned ZZ_W     = 2 * CHARGE_W;
    localparam int unsigned MAG_W    = COORD_W + 1;
    localparam int unsigned D2_W     = 2 * MAG_W;
    localparam int unsigned ROOT_W   = D2_W / 2;
    localparam int unsigned REM_W    = ROOT_W + 3;
    localparam int unsigned FRAC_SH  = 40;
    localparam int unsigned NUM_W    = ZZ_W + FRAC_SH + 1;
    localparam int unsigned TERM_W   = NUM_W;
    localparam int unsigned ACC_W    = 63;
    localparam int unsigned STAT_W   = 2;
    localparam int unsigned ATOM_W   = 3 * COORD_W + CHARGE_W;
    localparam int unsigned IN_DATA_W  = ((ATOM_W + 7) / 8) * 8;
    localparam int unsigned OUT_DATA_W = ((ACC_W + 7) / 8) * 8;
    localparam int unsigned STEP_W   = 6;

    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

    localparam int unsigned ST_COINCIDENT = 0;
    localparam int unsigned ST_DROPPED    = 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_DIFF,
        S_SQR,
        S_SUM,
        S_WAIT,
        S_NEXT,
        S_STORE,
        S_FIN
    } t_core_state;

    typedef enum logic [1:0] {
        U_IDLE,
        U_SQRT,
        U_PREP,
        U_DIV
    } t_unit_state;

    typedef struct packed {
        logic              start;
        logic [D2_W-1:0]   d2;
        logic [ZZ_W-1:0]   zz;
    } t_pair_req;

    typedef struct packed {
        logic              done;
        logic [TERM_W-1:0] term;
    } t_pair_rsp;

endpackage

FILE: rtl/core/nuclear_repulsion_energy_core.sv
// Nuclear repulsion energy core: sums Zi*Zj/Rij over all atom pairs.
// Each stored atom is paired with the new one: read, diff, square and sum, then the shared
// root/divide unit (square root steps, prepare, divide steps, result), then advance; a coincident
// pair skips the unit and is flagged. One atom at a time.
// Result is registered in the finish state after the final atom is stored, later while the previous
// result is still held. Reset (i_rst_n, synchronous, active low) clears count,
// energy and status; the atom memory is not cleared, only entries below the count are read.
// Depends on nre_pkg and nre_root_div.
module nuclear_repulsion_energy_core #(
    parameter int unsigned MAX_ATOMS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // pos_x[31:0], pos_y[63:32], pos_z[95:64], nuclear_charge[102:96], zero pad
    input  logic [nre_pkg::IN_DATA_W-1:0]   i_s_tdata,
    input  logic                            i_s_tlast,   // final_atom
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // energy[62:0], zero pad
    output logic [nre_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    // status[1:0]
    output logic [nre_pkg::STAT_W-1:0]      o_m_tuser
);
    import nre_pkg::*;

    localparam int unsigned AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
    localparam int unsigned CW = $clog2(MAX_ATOMS + 1);

    t_core_state          r_state, n_state;

    // atom memory: charge, z, y, x from the top bit down
    logic [ATOM_W-1:0]    r_mem [MAX_ATOMS];
    logic [ATOM_W-1:0]    r_rd;

    logic [ATOM_W-1:0]    r_atom;
    logic                 r_last;
    logic [CW-1:0]        r_count;
    logic [AW-1:0]        r_k;
    logic [ACC_W-1:0]     r_acc;
    logic [STAT_W-1:0]    r_flags;

    logic [MAG_W-1:0]     r_mx, r_my, r_mz;
    logic [ZZ_W-1:0]      r_zz;
    logic [D2_W-1:0]      r_sx, r_sy, r_sz;

    logic                 r_ovalid;
    logic [ACC_W-1:0]     r_oenergy;
    logic [STAT_W-1:0]    r_ostat;

    t_pair_req            pair_req;
    t_pair_rsp            pair_rsp;

    logic                 s_acc;
    logic                 last_k;
    logic [D2_W-1:0]      d2_sum;
    logic [ACC_W:0]       acc_sum;

    function automatic logic [MAG_W-1:0] f_absdiff(
        input logic [COORD_W-1:0] a,
        input logic [COORD_W-1:0] b
    );
        logic [MAG_W-1:0] d;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        return d[MAG_W-1] ? (~d + 1'b1) : d;
    endfunction

    assign s_acc   = i_s_tvalid && o_s_tready;
    assign last_k  = (CW'(r_k) + 1'b1) == r_count;
    assign d2_sum  = r_sx + r_sy + r_sz;
    assign acc_sum = {1'b0, r_acc} + {{(ACC_W + 1 - TERM_W){1'b0}}, pair_rsp.term};

    assign pair_req.start = (r_state == S_SUM) && (d2_sum != '0);
    assign pair_req.d2    = d2_sum;
    assign pair_req.zz    = r_zz;

    nre_root_div u_root_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (pair_req),
        .o_rsp  (pair_rsp)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    if (r_count == CW'(MAX_ATOMS)) begin
                        n_state = i_s_tlast ? S_FIN : S_IDLE;
                    end else if (r_count == '0) begin
                        n_state = S_STORE;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ:  n_state = S_DIFF;
            S_DIFF:  n_state = S_SQR;
            S_SQR:   n_state = S_SUM;
            S_SUM:   n_state = (d2_sum == '0) ? S_NEXT : S_WAIT;
            S_WAIT:  if (pair_rsp.done) n_state = S_NEXT;
            S_NEXT:  n_state = last_k ? S_STORE : S_READ;
            S_STORE: n_state = r_last ? S_FIN : S_IDLE;
            S_FIN:   if (!r_ovalid || i_m_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_acc    <= '0;
            r_flags  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            // load a new result when the holding register is free, drop it once taken
            r_ovalid <= ((r_state == S_FIN) && (!r_ovalid || i_m_tready))
                     || (r_ovalid && !i_m_tready);
            unique case (r_state)
                S_IDLE: begin
                    if (s_acc && r_count == CW'(MAX_ATOMS)) r_flags[ST_DROPPED] <= 1'b1;
                end
                S_SUM: begin
                    if (d2_sum == '0) r_flags[ST_COINCIDENT] <= 1'b1;
                end
                S_WAIT: begin
                    // saturate at the top of the accumulator
                    if (pair_rsp.done) begin
                        r_acc <= acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
                    end
                end
                S_STORE: r_count <= r_count + 1'b1;
                S_FIN: begin
                    if (!r_ovalid || i_m_tready) begin
                        r_count  <= '0;
                        r_acc    <= '0;
                        r_flags  <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_atom <= i_s_tdata[ATOM_W-1:0];
            r_last <= i_s_tlast;
            r_k    <= '0;
        end
        if (r_state == S_NEXT) r_k <= r_k + 1'b1;
        if (r_state == S_DIFF) begin
            r_mx <= f_absdiff(r_atom[COORD_W-1:0], r_rd[COORD_W-1:0]);
            r_my <= f_absdiff(r_atom[2*COORD_W-1:COORD_W], r_rd[2*COORD_W-1:COORD_W]);
            r_mz <= f_absdiff(r_atom[3*COORD_W-1:2*COORD_W], r_rd[3*COORD_W-1:2*COORD_W]);
            r_zz <= r_atom[ATOM_W-1:3*COORD_W] * r_rd[ATOM_W-1:3*COORD_W];
        end
        if (r_state == S_SQR) begin
            r_sx <= r_mx * r_mx;
            r_sy <= r_my * r_my;
            r_sz <= r_mz * r_mz;
        end
        if (r_state == S_FIN && (!r_ovalid || i_m_tready)) begin
            r_oenergy <= r_acc;
            r_ostat   <= r_flags;
        end
    end

    // atom memory: one read and one write port, read data registered
    always_ff @(posedge i_clk) begin
        if (r_state == S_STORE) r_mem[r_count[AW-1:0]] <= r_atom;
        r_rd <= r_mem[r_k];
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {{(OUT_DATA_W - ACC_W){1'b0}}, r_oenergy};
    assign o_m_tuser  = r_ostat;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ATOMS))
        else $error("atom count beyond capacity");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (CW'(r_k) < r_count))
        else $error("read of an unstored atom");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pair_rsp.done |-> (r_state == S_WAIT))
        else $error("pair result outside wait");

    a_drop_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && r_count == CW'(MAX_ATOMS) && !i_s_tlast) |=> r_flags[ST_DROPPED])
        else $error("dropped atom not flagged");

endmodule

FILE: rtl/core/nre_root_div.sv
// Pair term unit: integer square root of d2, then rounded Zi*Zj*2^40 / r.
// One result bit per cycle for both stages. Depends on nre_pkg.
module nre_root_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  nre_pkg::t_pair_req i_req,
    output nre_pkg::t_pair_rsp o_rsp
);
    import nre_pkg::*;

    t_unit_state         r_state, n_state;
    logic [D2_W-1:0]     r_rad;
    logic [REM_W-1:0]    r_rem;
    logic [ROOT_W-1:0]   r_root;
    logic [ZZ_W-1:0]     r_zz;
    logic [NUM_W-1:0]    r_quo;
    logic [STEP_W-1:0]   r_step;
    logic                r_done;

    logic [REM_W-1:0]    sq_rem;
    logic [REM_W-1:0]    sq_trial;
    logic [REM_W-1:0]    dv_rem;
    logic [REM_W-1:0]    dv_div;

    assign sq_rem   = {r_rem[REM_W-3:0], r_rad[D2_W-1 -: 2]};
    assign sq_trial = {1'b0, r_root, 2'b01};
    assign dv_rem   = {r_rem[REM_W-2:0], r_quo[NUM_W-1]};
    assign dv_div   = {{(REM_W-ROOT_W){1'b0}}, r_root};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            U_IDLE: if (i_req.start) n_state = U_SQRT;
            U_SQRT: if (r_step == STEP_W'(ROOT_W - 1)) n_state = U_PREP;
            U_PREP: n_state = U_DIV;
            U_DIV:  if (r_step == STEP_W'(NUM_W - 1)) n_state = U_IDLE;
            default: n_state = U_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == U_DIV) && (r_step == STEP_W'(NUM_W - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            U_IDLE: begin
                r_rad  <= i_req.d2;
                r_zz   <= i_req.zz;
                r_rem  <= '0;
                r_root <= '0;
                r_step <= '0;
            end
            U_SQRT: begin
                r_rad  <= {r_rad[D2_W-3:0], 2'b00};
                r_step <= r_step + 1'b1;
                if (sq_rem >= sq_trial) begin
                    r_rem  <= sq_rem - sq_trial;
                    r_root <= {r_root[ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem  <= sq_rem;
                    r_root <= {r_root[ROOT_W-2:0], 1'b0};
                end
            end
            U_PREP: begin
                // add half the divisor for round-half-up
                r_quo  <= {1'b0, r_zz, {FRAC_SH{1'b0}}}
                        + {{(NUM_W-ROOT_W+1){1'b0}}, r_root[ROOT_W-1:1]};
                r_rem  <= '0;
                r_step <= '0;
            end
            U_DIV: begin
                r_step <= r_step + 1'b1;
                if (dv_rem >= dv_div) begin
                    r_rem <= dv_rem - dv_div;
                    r_quo <= {r_quo[NUM_W-2:0], 1'b1};
                end else begin
                    r_rem <= dv_rem;
                    r_quo <= {r_quo[NUM_W-2:0], 1'b0};
                end
            end
            default: ;
        endcase
    end

    assign o_rsp.done = r_done;
    assign o_rsp.term = r_quo;

endmodule

FILE: sim/nuclear_repulsion_energy_core_tb.sv
// Self-checking testbench for nuclear_repulsion_energy_core: atoms are streamed in,
// and each molecule energy and status is checked against an in-bench pair-sum predictor.
// Depends on nre_pkg and the core RTL.
module nuclear_repulsion_energy_core_tb;
    import nre_pkg::*;

    localparam int MOL_CAP   = 64;
    localparam int RAND_GOAL = 1300;

    typedef struct {
        logic signed [31:0] x, y, z;
        logic [6:0]         q;
        logic               fin;
    } t_atom;

    typedef struct {
        logic [62:0] energy;
        logic [1:0]  status;
    } t_mol_res;

    typedef struct {
        t_atom       a;
        bit          typed;
        logic [62:0] energy;
        logic [1:0]  status;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata = '0;
    logic                  i_s_tlast = 1'b0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic [STAT_W-1:0]     o_m_tuser;

    nuclear_repulsion_energy_core dut (.*);

    always #10 i_clk = ~i_clk;

    // predictor state: one molecule in flight
    logic signed [31:0] mol_x[MOL_CAP], mol_y[MOL_CAP], mol_z[MOL_CAP];
    logic [6:0]         mol_q[MOL_CAP];
    int                 mol_n = 0;
    logic [62:0]        mol_energy = '0;
    logic [1:0]         mol_status = '0;

    t_mol_res energy_q[$];
    int       errs = 0;
    int       results_seen = 0;
    bit       quiet = 0;

    task automatic report(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        errs++;
    endtask

    function automatic logic [63:0] pair_energy(input t_atom a, input int k);
        logic signed [67:0] dx, dy, dz;
        logic [67:0]        d2, c, root;
        logic [63:0]        num;
        dx = 68'(a.x) - 68'(mol_x[k]);
        dy = 68'(a.y) - 68'(mol_y[k]);
        dz = 68'(a.z) - 68'(mol_z[k]);
        d2 = dx * dx + dy * dy + dz * dz;
        if (d2 == 0) begin
            return '1;  // flag: coincident
        end
        root = '0;
        for (int b = 33; b >= 0; b--) begin
            c = root | (68'd1 << b);
            if (c * c <= d2) begin
                root = c;
            end
        end
        num = (64'(a.q) * 64'(mol_q[k])) << 40;
        return (num + 64'(root >> 1)) / 64'(root);
    endfunction

    // Fold one accepted atom into the molecule; returns 1 with the result on a final atom.
    function automatic bit absorb_atom(input t_atom a, output t_mol_res r);
        logic [63:0] term;
        if (mol_n < MOL_CAP) begin
            for (int k = 0; k < mol_n; k++) begin
                term = pair_energy(a, k);
                if (term == '1) begin
                    mol_status[0] = 1'b1;
                end else if (term > 64'(ACC_MAX - mol_energy)) begin
                    mol_energy = ACC_MAX;
                end else begin
                    mol_energy = mol_energy + 63'(term);
                end
            end
            mol_x[mol_n] = a.x;
            mol_y[mol_n] = a.y;
            mol_z[mol_n] = a.z;
            mol_q[mol_n] = a.q;
            mol_n++;
        end else begin
            mol_status[1] = 1'b1;
        end
        r.energy = mol_energy;
        r.status = mol_status;
        if (a.fin) begin
            mol_n = 0;
            mol_energy = '0;
            mol_status = '0;
        end
        return a.fin;
    endfunction

    // Offer one atom from the falling edge until it is taken; idle afterwards at random.
    task automatic send_atom(input t_atom a, input bit typed,
                             input logic [62:0] e, input logic [1:0] s);
        t_mol_res r;
        @(negedge i_clk);
        i_s_tvalid = 1'b1;
        i_s_tdata  = {{(IN_DATA_W - 103){1'b0}}, a.q, a.z, a.y, a.x};
        i_s_tlast  = a.fin;
        do @(posedge i_clk); while (!o_s_tready);
        if (absorb_atom(a, r)) begin
            if (typed) begin
                r.energy = e;
                r.status = s;
            end
            energy_q.push_back(r);
        end
        if (!quiet && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            i_s_tvalid = 1'b0;
            repeat ($urandom_range(0, 12)) @(negedge i_clk);
        end
    endtask

    // Result side: random stall bursts, one long hold-off to back the core up.
    initial begin
        int hold;
        bit long_done;
        hold = 0;
        long_done = 0;
        forever begin
            @(negedge i_clk);
            if (!long_done && results_seen == 3) begin
                hold = 4000;
                long_done = 1;
            end else if (hold == 0 && !quiet && $urandom_range(0, 7) == 0) begin
                hold = $urandom_range(1, 13);
            end
            if (quiet && hold > 13) hold = 0;
            i_m_tready = (hold == 0);
            if (hold > 0) hold--;
            @(posedge i_clk);
            if (o_m_tvalid && i_m_tready && i_rst_n) begin
                results_seen++;
                if (energy_q.size() == 0) begin
                    report("result with nothing expected");
                end else begin
                    t_mol_res exp_r;
                    exp_r = energy_q.pop_front();
                    if (o_m_tdata[62:0] !== exp_r.energy)
                        report($sformatf("energy %h, expected %h",
                                         o_m_tdata[62:0], exp_r.energy));
                    if (o_m_tdata[OUT_DATA_W-1:63] !== '0)
                        report("energy padding not zero");
                    if (o_m_tuser !== exp_r.status)
                        report($sformatf("status %0d, expected %0d",
                                         o_m_tuser, exp_r.status));
                end
            end
        end
    end

    function automatic t_atom mk(input logic [31:0] x, y, z, input logic [6:0] q,
                                 input logic fin);
        t_atom a;
        a.x = x; a.y = y; a.z = z; a.q = q; a.fin = fin;
        return a;
    endfunction

    initial begin
        t_row  rows[$];
        t_row  rw;
        t_atom a, prev;
        int    sent, n;
        logic [31:0] bx, by, bz;
        bit    wide, big_done;

        // directed rows; energy typed in only where it is obvious
        rw.typed = 1; rw.energy = '0; rw.status = 2'd0;
        rw.a = mk(0, 0, 0, 1, 1);                        rows.push_back(rw); // lone atom
        rw.typed = 0;
        rw.a = mk(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 127, 0); rows.push_back(rw);
        rw.typed = 1; rw.status = 2'd1;                                    // coincident pair
        rw.a = mk(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 127, 1); rows.push_back(rw);
        rw.typed = 0;
        rw.a = mk(0, 0, 0, 1, 0);                        rows.push_back(rw);
        rw.typed = 1; rw.energy = 63'(64'd1 << 40); rw.status = 2'd0;      // unit distance
        rw.a = mk(1, 0, 0, 1, 1);                        rows.push_back(rw);
        rw.typed = 0;
        rw.a = mk(32'h80000000, 32'h80000000, 32'h80000000, 127, 0); rows.push_back(rw);
        rw.a = mk(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 127, 1); rows.push_back(rw);
        rw.a = mk(32'h00010000, 0, 0, 0, 0);             rows.push_back(rw);
        rw.typed = 1; rw.energy = '0; rw.status = 2'd0;                    // zero charge
        rw.a = mk(0, 0, 0, 127, 1);                      rows.push_back(rw);
        rw.typed = 0;
        rw.a = mk(32'h80000000, 0, 32'h7FFFFFFF, 85, 0); rows.push_back(rw);
        rw.a = mk(32'h7FFFFFFF, 32'h80000000, 0, 42, 0); rows.push_back(rw);
        rw.a = mk(32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 7'h55, 0); rows.push_back(rw);
        rw.a = mk(32'h55555555, 32'hAAAAAAAA, 32'h55555555, 7'h2A, 1); rows.push_back(rw);

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[i]) send_atom(rows[i].a, rows[i].typed, rows[i].energy, rows[i].status);

        // random molecules, one dense overfull molecule to hit saturation and drops
        sent = 0;
        big_done = 0;
        prev = mk(0, 0, 0, 1, 0);
        while (sent < RAND_GOAL) begin
            if (sent > RAND_GOAL * 9 / 10) quiet = 1;
            if (!big_done && sent > 300) begin
                for (int k = 0; k < 66; k++) begin
                    a = mk(k % 4, (k / 4) % 4, (k / 16) % 4, 127, k == 65);
                    send_atom(a, 0, '0, '0);
                end
                big_done = 1;
                sent += 66;
                continue;
            end
            n = ($urandom_range(0, 39) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
            wide = ($urandom_range(0, 2) == 0);
            bx = $urandom; by = $urandom; bz = $urandom;
            for (int k = 0; k < n; k++) begin
                if (wide) begin
                    a = mk($urandom, $urandom, $urandom, $urandom_range(0, 127), 0);
                end else begin
                    a = mk(bx + $urandom_range(0, 32'h3FFFF) - 32'h1FFFF,
                           by + $urandom_range(0, 32'h3FFFF) - 32'h1FFFF,
                           bz + $urandom_range(0, 32'h3FFFF) - 32'h1FFFF,
                           $urandom_range(0, 127), 0);
                end
                if (k > 0 && $urandom_range(0, 9) == 0) begin
                    a.x = prev.x; a.y = prev.y; a.z = prev.z;   // land on the last atom
                end
                a.fin = (k == n - 1);
                send_atom(a, 0, '0, '0);
                prev = a;
                sent++;
            end
        end
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        i_s_tlast  = 1'b0;

        wait (energy_q.size() == 0);
        repeat (300) @(posedge i_clk);
        if (errs == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #80_000_000;
        $display("simulation failed");
        $finish;
    end
endmodule

FILE: nuclear_repulsion_energy_core.f
rtl/core/nre_pkg.sv
rtl/core/nre_root_div.sv
rtl/core/nuclear_repulsion_energy_core.sv
sim/nuclear_repulsion_energy_core_tb.sv
